/* rtl/core/crtv_pkg.sv */
// Shared constants and types for the correlation to t value converter.
package crtv_pkg;

  localparam int R_W = 16;
  localparam int T_W = 32;
  localparam int N_W = 16;
  localparam int R_FRAC_BITS = 14;
  localparam int T_FRAC_BITS = 10;

  localparam int MAG_W  = R_FRAC_BITS + 1;
  localparam int SQ_W   = 2 * R_FRAC_BITS + 1;
  localparam int M_W    = SQ_W - 1 + N_W;
  localparam int NUM_W  = M_W + 2 * T_FRAC_BITS;
  localparam int D_MIN_W = R_FRAC_BITS + 1;
  localparam int Q_W    = NUM_W - D_MIN_W;
  localparam int SQI_W  = Q_W + (Q_W % 2);
  localparam int ROOT_W = SQI_W / 2;
  localparam int SREM_W = ROOT_W + 1;

  localparam logic [MAG_W-1:0] R_ONE = MAG_W'(1) << R_FRAC_BITS;
  localparam logic [SQ_W-1:0] R_ONE_SQ = SQ_W'(1) << (2 * R_FRAC_BITS);
  localparam logic [T_W-1:0] UNIT_T = T_W'(64'd1000000 << T_FRAC_BITS);
  localparam logic [N_W-1:0] MIN_SUBJECTS = N_W'(3);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_R    = 2'd1;
  localparam logic [1:0] ST_FEW_SUBJ = 2'd2;

  typedef struct packed {
    logic       neg;
    logic       unit;
    logic [1:0] status;
  } side_t;

endpackage

/* rtl/core/crtv_in_if.sv */
// Input channel: correlation transaction.
interface crtv_in_if;
  import crtv_pkg::*;
  logic           valid;
  logic           ready;
  logic [R_W-1:0] r_value;
  logic           r_not_finite;
  modport source (output valid, r_value, r_not_finite, input ready);
  modport sink (input valid, r_value, r_not_finite, output ready);
endinterface

/* rtl/core/crtv_out_if.sv */
// Result channel: t value transaction.
interface crtv_out_if;
  import crtv_pkg::*;
  logic           valid;
  logic           ready;
  logic [T_W-1:0] t_value;
  logic [1:0]     status;
  modport source (output valid, t_value, status, input ready);
  modport sink (input valid, t_value, status, output ready);
endinterface

/* rtl/core/correlation_to_t_value.sv */
// Top level: correlation r to Student t value converter.
// One transaction enters per cycle while the skid register is empty, and its result
// passes through input check, square, product with N-2, a load stage plus one stage
// per quotient bit of the divider (50), a load stage plus one stage per root bit (26)
// and an output register, 80 register stages. Throughput is one per cycle while the
// output is not stalled; a stalled result sits in a skid register while the pipeline
// holds. The user must write num_subjects only while the block is idle; the block
// itself does not enforce it.
module correlation_to_t_value import crtv_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [N_W-1:0] cfg_wdata,
  crtv_in_if.sink        in_ch,
  crtv_out_if.source     out_ch
);

  logic [N_W-1:0] num_subj_r;
  logic           en;
  logic           skid_full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_subj_r <= '0;
    end else if (cfg_we) begin
      num_subj_r <= cfg_wdata;
    end
  end

  assign en          = !skid_full_r;
  assign in_ch.ready = en;

  // stage 0: magnitude and checks
  logic             s0_v_r;
  logic [MAG_W-1:0] s0_mag_r;
  side_t            s0_side_r;
  logic [R_W-1:0]   mag_full;
  logic             bad_r;
  side_t            side_nxt;

  always_comb begin
    mag_full = in_ch.r_value[R_W-1] ? R_W'(0) - in_ch.r_value : in_ch.r_value;
    bad_r    = in_ch.r_not_finite || (mag_full > R_W'(R_ONE));
    side_nxt.neg  = in_ch.r_value[R_W-1];
    side_nxt.unit = (mag_full == R_W'(R_ONE));
    if (bad_r) begin
      side_nxt.status = ST_BAD_R;
    end else if (num_subj_r < MIN_SUBJECTS) begin
      side_nxt.status = ST_FEW_SUBJ;
    end else begin
      side_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mag_r  <= bad_r ? '0 : mag_full[MAG_W-1:0];
      s0_side_r <= side_nxt;
    end
  end

  // stage 1: square
  logic            s1_v_r;
  logic [SQ_W-1:0] s1_sq_r;
  logic [N_W-1:0]  s1_nm2_r;
  side_t           s1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sq_r   <= SQ_W'(s0_mag_r * s0_mag_r);
      s1_nm2_r  <= num_subj_r - N_W'(2);
      s1_side_r <= s0_side_r;
    end
  end

  // stage 2: numerator and denominator
  logic            s2_v_r;
  logic [M_W-1:0]  s2_m_r;
  logic [SQ_W-1:0] s2_d_r;
  side_t           s2_side_r;
  logic            s2_special;

  assign s2_special = s1_side_r.unit || (s1_side_r.status != ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_m_r    <= s2_special ? '0 : M_W'(s1_sq_r[SQ_W-2:0] * s1_nm2_r);
      s2_d_r    <= s2_special ? SQ_W'(1) : R_ONE_SQ - s1_sq_r;
      s2_side_r <= s1_side_r;
    end
  end

  logic              rp_v;
  logic [ROOT_W-1:0] rp_root;
  side_t             rp_side;

  crtv_root_pipe u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (s2_v_r),
    .m        (s2_m_r),
    .d        (s2_d_r),
    .in_side  (s2_side_r),
    .out_v    (rp_v),
    .root     (rp_root),
    .out_side (rp_side)
  );

  // output register and skid
  logic           o_v_r;
  logic [T_W-1:0] o_t_r;
  logic [1:0]     o_st_r;
  logic [T_W-1:0] skid_t_r;
  logic [1:0]     skid_st_r;
  logic [T_W-1:0] tmag;

  always_comb begin
    if (rp_side.status != ST_OK) begin
      tmag = '0;
    end else if (rp_side.unit) begin
      tmag = UNIT_T;
    end else begin
      tmag = T_W'(rp_root);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r       <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      if (en) begin
        o_v_r <= rp_v;
      end
      if (skid_full_r && out_ch.ready) begin
        skid_full_r <= 1'b0;
      end else if (en && o_v_r && !out_ch.ready) begin
        skid_full_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_t_r     <= rp_side.neg ? T_W'(0) - tmag : tmag;
      o_st_r    <= rp_side.status;
      skid_t_r  <= o_t_r;
      skid_st_r <= o_st_r;
    end
  end

  assign out_ch.valid   = skid_full_r || o_v_r;
  assign out_ch.t_value = skid_full_r ? skid_t_r : o_t_r;
  assign out_ch.status  = skid_full_r ? skid_st_r : o_st_r;

  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != ST_OK) |-> out_ch.t_value == '0)
    else $error("nonzero t with error status");

  a_skid_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> !in_ch.ready)
    else $error("skid full while input open");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status == ST_OK || out_ch.status == ST_BAD_R ||
                     out_ch.status == ST_FEW_SUBJ)
    else $error("undefined status code");

endmodule

/* rtl/core/crtv_root_pipe.sv */
// Pipelined floor(sqrt(m * 2^(2T) / d)): one quotient bit, then one root bit per stage.
module crtv_root_pipe import crtv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [M_W-1:0]    m,
  input  logic [SQ_W-1:0]   d,
  input  side_t             in_side,
  output logic              out_v,
  output logic [ROOT_W-1:0] root,
  output side_t             out_side
);

  logic             dv_r   [0:Q_W];
  logic [SQ_W-1:0]  drem_r [0:Q_W];
  logic [SQ_W-1:0]  dd_r   [0:Q_W];
  logic [Q_W-1:0]   dnum_r [0:Q_W];
  logic [Q_W-1:0]   dquo_r [0:Q_W];
  side_t            dside_r[0:Q_W];

  logic              sv_r   [0:ROOT_W];
  logic [SREM_W-1:0] srem_r [0:ROOT_W];
  logic [ROOT_W-1:0] sroot_r[0:ROOT_W];
  logic [SQI_W-1:0]  sbits_r[0:ROOT_W];
  side_t             sside_r[0:ROOT_W];

  logic [NUM_W-1:0] num_full;
  assign num_full = {m, {(2 * T_FRAC_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
      sv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= in_v;
      sv_r[0] <= dv_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem_r[0]  <= SQ_W'(num_full[NUM_W-1:Q_W]);
      dd_r[0]    <= d;
      dnum_r[0]  <= num_full[Q_W-1:0];
      dquo_r[0]  <= '0;
      dside_r[0] <= in_side;
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
      sbits_r[0] <= SQI_W'(dquo_r[Q_W]);
      sside_r[0] <= dside_r[Q_W];
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    logic [SQ_W-1:0] rs;
    logic            ge;
    assign rs = {drem_r[k][SQ_W-2:0], dnum_r[k][Q_W-1]};
    assign ge = rs >= dd_r[k];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[k+1]  <= ge ? rs - dd_r[k] : rs;
        dd_r[k+1]    <= dd_r[k];
        dnum_r[k+1]  <= {dnum_r[k][Q_W-2:0], 1'b0};
        dquo_r[k+1]  <= {dquo_r[k][Q_W-2:0], ge};
        dside_r[k+1] <= dside_r[k];
      end
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [SREM_W+1:0] rr;
    logic [SREM_W+1:0] trial;
    logic              ge;
    logic [SREM_W+1:0] diff;
    assign rr    = {srem_r[k], sbits_r[k][SQI_W-1:SQI_W-2]};
    assign trial = (SREM_W+2)'({sroot_r[k], 2'b01});
    assign ge    = rr >= trial;
    assign diff  = ge ? rr - trial : rr;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else if (en) begin
        sv_r[k+1] <= sv_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[k+1]  <= diff[SREM_W-1:0];
        sroot_r[k+1] <= {sroot_r[k][ROOT_W-2:0], ge};
        sbits_r[k+1] <= {sbits_r[k][SQI_W-3:0], 2'b00};
        sside_r[k+1] <= sside_r[k];
      end
    end
  end

  assign out_v    = sv_r[ROOT_W];
  assign root     = sroot_r[ROOT_W];
  assign out_side = sside_r[ROOT_W];

endmodule
